// ----- hdl/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants
// Request layout, operation codes and register indexes of the I2C master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int DEV_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int TICK_W  = 16;
  localparam int POLL_W  = 8;
  localparam int OP_W    = 2;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 16;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 16;

  // request queue depth
  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);

  // operation codes on the input channel
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_AW-1:0] REG_SETUP       = 2'd1;
  localparam logic [CFG_AW-1:0] REG_HOLD        = 2'd2;
  localparam logic [CFG_AW-1:0] REG_POLL_LIMIT  = 2'd3;

  // reset values
  localparam logic [TICK_W-1:0] HALF_PERIOD_RST = 16'd5;
  localparam logic [TICK_W-1:0] SETUP_RST       = 16'd2;
  localparam logic [TICK_W-1:0] HOLD_RST        = 16'd3;
  localparam logic [POLL_W-1:0] POLL_LIMIT_RST  = 8'd50;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_READ,
    KIND_WRITE
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [DEV_W-1:0]   dev_addr;
    logic [BYTE_W-1:0]  reg_addr;
    logic [BYTE_W-1:0]  byte_count;
    logic [BYTE_W-1:0]  write_byte;
    logic               sda_in;
  } req_t;

endpackage

// ----- hdl/i2cm_front.sv -----
// ----------------------------------------------------------------------------
// i2cm_front: request intake
// Takes stream requests, decodes the operation and pushes into the queue.
// ----------------------------------------------------------------------------
module i2cm_front
  import i2cm_pkg::*;
(
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,
  input  logic [OP_W-1:0] in_tuser,
  output logic            push_valid,
  input  logic            push_ready,
  output req_t            push_req
);

  kind_t kind;

  // code three acts as tick only
  always_comb begin
    case (in_tuser)
      OP_READ:  kind = KIND_READ;
      OP_WRITE: kind = KIND_WRITE;
      default:  kind = KIND_TICK;
    endcase
  end

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;

  always_comb begin
    push_req.kind       = kind;
    push_req.dev_addr   = in_tdata[6:0];
    push_req.reg_addr   = in_tdata[14:7];
    push_req.byte_count = in_tdata[22:15];
    push_req.write_byte = in_tdata[30:23];
    push_req.sda_in     = in_tdata[31];
  end

endmodule

// ----- hdl/i2cm_queue.sv -----
// ----------------------------------------------------------------------------
// i2cm_queue: request queue
// Small register FIFO between intake and bus sequencer.
// ----------------------------------------------------------------------------
module i2cm_queue
  import i2cm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  req_t push_req,
  output logic pop_valid,
  input  logic pop_ready,
  output req_t pop_req
);

  req_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r;
  logic           push, pop;

  assign push_ready = (count_r != QAW'(0) + (QAW+1)'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_req    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + (QAW+1)'(1);
        2'b01:   count_r <= count_r - (QAW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- hdl/i2cm_engine.sv -----
// ----------------------------------------------------------------------------
// i2cm_engine: bus sequencer
// Runs one timing tick per request and registers the resulting line levels.
// ----------------------------------------------------------------------------
module i2cm_engine
  import i2cm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_SDA, PH_ST_SCL, PH_TX_DATA, PH_TX_HIGH, PH_TX_LOW,
    PH_ACK_REL, PH_ACK_POLL, PH_ACK_LOW, PH_AFTER, PH_RX_LOW, PH_RX_HIGH,
    PH_RACK_SET, PH_RACK_HIGH, PH_RACK_LOW, PH_SP_HIGH, PH_SP_END
  } phase_t;

  typedef enum logic [1:0] {
    STG_DEVW, STG_REG, STG_DEVR, STG_DATA
  } stage_t;

  logic [TICK_W-1:0] half_r, setup_r, hold_r;
  logic [POLL_W-1:0] limit_r;

  phase_t            phase_r, phase_nxt;
  stage_t            stage_r, stage_nxt;
  logic [TICK_W-1:0] wait_r, wait_nxt;
  logic [3:0]        bit_r, bit_nxt;
  logic [BYTE_W-1:0] shift_r, shift_nxt;
  logic [BYTE_W-1:0] bytes_r, bytes_nxt;
  logic [POLL_W-1:0] poll_r, poll_nxt;
  logic [DEV_W-1:0]  dev_r, dev_nxt;
  logic [BYTE_W-1:0] reg_r, reg_nxt;
  logic              is_read_r, is_read_nxt;
  logic              scl_r, scl_nxt, sda_r, sda_nxt;
  logic              err_r, err_nxt;

  logic              o_valid, o_taken, o_err, o_done;
  logic [BYTE_W-1:0] o_data;
  logic              tx_go, stop_go;
  logic [BYTE_W-1:0] tx_src, rx_byte;
  logic [3:0]        bit_inc;
  logic              fire;

  logic              out_tvalid_r;
  logic [OUT_W-1:0]  out_tdata_r;

  assign req_ready  = !out_tvalid_r || out_tready;
  assign fire       = req_valid && req_ready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign bit_inc    = bit_r + 4'd1;
  assign rx_byte    = {shift_r[BYTE_W-2:0], req.sda_in};

  always_comb begin
    phase_nxt   = phase_r;
    stage_nxt   = stage_r;
    wait_nxt    = wait_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    bytes_nxt   = bytes_r;
    poll_nxt    = poll_r;
    dev_nxt     = dev_r;
    reg_nxt     = reg_r;
    is_read_nxt = is_read_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    err_nxt     = err_r;
    o_valid     = 1'b0;
    o_taken     = 1'b0;
    o_err       = 1'b0;
    o_done      = 1'b0;
    o_data      = '0;
    tx_go       = 1'b0;
    stop_go     = 1'b0;
    tx_src      = shift_r;

    if (phase_r == PH_IDLE) begin
      if (req.kind == KIND_READ || req.kind == KIND_WRITE) begin
        dev_nxt     = req.dev_addr;
        reg_nxt     = req.reg_addr;
        bytes_nxt   = req.byte_count;
        is_read_nxt = (req.kind == KIND_READ);
        stage_nxt   = STG_DEVW;
        err_nxt     = 1'b0;
        scl_nxt     = 1'b1;
        sda_nxt     = 1'b1;
        phase_nxt   = PH_ST_SDA;
        wait_nxt    = half_r;
      end
    end else if (wait_r > 16'd1) begin
      wait_nxt = wait_r - 16'd1;
    end else begin
      case (phase_r)
        PH_ST_SDA: begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b0;
          phase_nxt = PH_ST_SCL;
          wait_nxt  = half_r;
        end
        PH_ST_SCL: begin
          scl_nxt   = 1'b0;
          shift_nxt = {dev_r, stage_r == STG_DEVR};
          bit_nxt   = '0;
          phase_nxt = PH_TX_DATA;
          wait_nxt  = 16'd1;
        end
        PH_TX_DATA: tx_go = 1'b1;
        PH_TX_HIGH: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_TX_LOW;
          wait_nxt  = half_r;
        end
        PH_TX_LOW: begin
          scl_nxt   = 1'b0;
          bit_nxt   = bit_inc;
          phase_nxt = (bit_inc < 4'd8) ? PH_TX_DATA : PH_ACK_REL;
          wait_nxt  = hold_r;
        end
        PH_ACK_REL: begin
          scl_nxt   = 1'b0;
          sda_nxt   = 1'b1;
          poll_nxt  = '0;
          phase_nxt = PH_ACK_POLL;
          wait_nxt  = half_r;
        end
        PH_ACK_POLL: begin
          if (req.sda_in) begin
            if (poll_r >= limit_r) begin
              err_nxt = 1'b1;
              stop_go = 1'b1;
            end else begin
              poll_nxt  = poll_r + 8'd1;
              phase_nxt = PH_ACK_POLL;
              wait_nxt  = half_r;
            end
          end else begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_ACK_LOW;
            wait_nxt  = half_r;
          end
        end
        PH_ACK_LOW, PH_RACK_LOW: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_AFTER;
          wait_nxt  = 16'd1;
        end
        PH_AFTER: begin
          if (stage_r == STG_DEVW) begin
            stage_nxt = STG_REG;
            bit_nxt   = '0;
            tx_src    = reg_r;
            tx_go     = 1'b1;
          end else if (stage_r == STG_REG && is_read_r) begin
            stage_nxt = STG_DEVR;
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
            phase_nxt = PH_ST_SDA;
            wait_nxt  = half_r;
          end else if (!is_read_r) begin
            stage_nxt = STG_DATA;
            shift_nxt = req.write_byte;
            if (bytes_r == '0) begin
              stop_go = 1'b1;
            end else begin
              bytes_nxt = bytes_r - 8'd1;
              o_taken   = 1'b1;
              bit_nxt   = '0;
              tx_src    = req.write_byte;
              tx_go     = 1'b1;
            end
          end else begin
            stage_nxt = STG_DATA;
            if (bytes_r == '0) begin
              stop_go = 1'b1;
            end else begin
              bit_nxt   = '0;
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b1;
              phase_nxt = PH_RX_HIGH;
              wait_nxt  = half_r;
            end
          end
        end
        PH_RX_LOW: begin
          scl_nxt   = 1'b0;
          sda_nxt   = 1'b1;
          phase_nxt = PH_RX_HIGH;
          wait_nxt  = half_r;
        end
        PH_RX_HIGH: begin
          scl_nxt   = 1'b1;
          shift_nxt = rx_byte;
          bit_nxt   = bit_inc;
          wait_nxt  = half_r;
          if (bit_inc >= 4'd8) begin
            o_valid   = 1'b1;
            o_data    = rx_byte;
            bytes_nxt = bytes_r - 8'd1;
            phase_nxt = PH_RACK_SET;
          end else begin
            phase_nxt = PH_RX_LOW;
          end
        end
        PH_RACK_SET: begin
          // NACK on the last byte
          scl_nxt   = 1'b0;
          sda_nxt   = (bytes_r == '0);
          phase_nxt = PH_RACK_HIGH;
          wait_nxt  = half_r;
        end
        PH_RACK_HIGH: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_RACK_LOW;
          wait_nxt  = half_r;
        end
        PH_SP_HIGH: begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          phase_nxt = PH_SP_END;
          wait_nxt  = half_r;
        end
        PH_SP_END: begin
          o_done    = 1'b1;
          o_err     = err_r;
          err_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
          wait_nxt  = '0;
        end
        default: begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          phase_nxt = PH_IDLE;
          wait_nxt  = '0;
        end
      endcase

      if (tx_go) begin
        scl_nxt   = 1'b0;
        sda_nxt   = tx_src[BYTE_W-1];
        shift_nxt = {tx_src[BYTE_W-2:0], 1'b0};
        phase_nxt = PH_TX_HIGH;
        wait_nxt  = setup_r;
      end
      if (stop_go) begin
        scl_nxt   = 1'b0;
        sda_nxt   = 1'b0;
        phase_nxt = PH_SP_HIGH;
        wait_nxt  = half_r;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= HALF_PERIOD_RST;
      setup_r <= SETUP_RST;
      hold_r  <= HOLD_RST;
      limit_r <= POLL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_HALF_PERIOD: half_r  <= cfg_wdata;
        REG_SETUP:       setup_r <= cfg_wdata;
        REG_HOLD:        hold_r  <= cfg_wdata;
        REG_POLL_LIMIT:  limit_r <= cfg_wdata[POLL_W-1:0];
        default:         half_r  <= half_r;
      endcase
    end
  end

  // sequencer state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      stage_r      <= STG_DEVW;
      wait_r       <= '0;
      bit_r        <= '0;
      shift_r      <= '0;
      bytes_r      <= '0;
      poll_r       <= '0;
      dev_r        <= '0;
      reg_r        <= '0;
      is_read_r    <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      err_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r   <= phase_nxt;
        stage_r   <= stage_nxt;
        wait_r    <= wait_nxt;
        bit_r     <= bit_nxt;
        shift_r   <= shift_nxt;
        bytes_r   <= bytes_nxt;
        poll_r    <= poll_nxt;
        dev_r     <= dev_nxt;
        reg_r     <= reg_nxt;
        is_read_r <= is_read_nxt;
        scl_r     <= scl_nxt;
        sda_r     <= sda_nxt;
        err_r     <= err_nxt;
      end
      if (fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_tdata_r <= {1'b0, (phase_nxt != PH_IDLE), o_done, o_err, o_taken, o_valid,
                      o_data, sda_nxt, scl_nxt};
    end
  end

endmodule

// ----- hdl/i2c_master_register_access_unit.sv -----
// An accepted request passes the queue register, then the sequencer's output register,
// before its result can be taken.
// Takes and retires one tick request per cycle unless the result channel stalls.
// A four-entry request queue decouples intake from the sequencer.
// Reset (rst_n low, synchronous): queue empty, sequencer idle, SCL/SDA high,
// timing registers back to 5/2/3/50, no result pending.
// ----------------------------------------------------------------------------
// i2c_master_register_access_unit: I2C register read/write master
// Each request is one timing tick of a bit-level I2C master running start,
// address, register, data, acknowledge and stop phases. Every request
// yields one result with the SCL/SDA levels and status strobes.
// ----------------------------------------------------------------------------
module i2c_master_register_access_unit
  import i2cm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration write port: 0 half period, 1 setup, 2 hold, 3 poll limit
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  // request channel
  input  logic              in_tvalid,
  output logic              in_tready,
  // tdata: dev_addr[6:0], reg_addr[14:7], byte_count[22:15],
  //        write_byte[30:23], sda_in[31]
  input  logic [IN_W-1:0]   in_tdata,
  // tuser: operation[1:0] (0 tick, 1 read, 2 write)
  input  logic [OP_W-1:0]   in_tuser,
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  // tdata: scl_level[0], sda_level[1], read_data[9:2], read_valid[10],
  //        write_taken[11], ack_error[12], done_res[13], busy_res[14], zero[15]
  output logic [OUT_W-1:0]  out_tdata
);

  // intake -> queue
  logic push_valid, push_ready;
  req_t push_req;

  // queue -> sequencer
  logic pop_valid, pop_ready;
  req_t pop_req;

  // intake: decode the operation, no state of its own
  i2cm_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req)
  );

  // short queue so intake keeps flowing while the result side stalls
  i2cm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_req    (pop_req)
  );

  // sequencer: steps the bus state once per request, output register after it
  i2cm_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .req_valid  (pop_valid),
    .req_ready  (pop_ready),
    .req        (pop_req),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- hdl/i2cm_checker.sv -----
// ----------------------------------------------------------------------------
// i2cm_checker: port checks
// Watches the result channel of the I2C master for consistent status.
// ----------------------------------------------------------------------------
module i2cm_checker
  import i2cm_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // done tick ends busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13] |-> !out_tdata[14])
    else $error("busy on done tick");

  // error only on a done tick
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12] |-> out_tdata[13])
    else $error("ack error without done");

  // a byte completes on rising SCL, a data byte is taken with SCL low
  a_rx_scl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10] |-> out_tdata[0] && !out_tdata[11])
    else $error("read strobe with SCL low");

  a_tx_scl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |-> !out_tdata[0] && out_tdata[14])
    else $error("write strobe with SCL high or idle");

endmodule

bind i2c_master_register_access_unit i2cm_checker u_i2cm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/i2cm_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_tb_pkg: bus-tick predictor and scoreboard
// Cycle-true model of the I2C register master, one step per request, plus
// the queue of expected line/status words that the result channel must match.
// ----------------------------------------------------------------------------
package i2cm_tb_pkg;

  import i2cm_pkg::*;

  // operation code with no meaning of its own: the block treats it as a tick
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_SDA, PH_ST_SCL, PH_TX_DATA, PH_TX_HIGH, PH_TX_LOW,
    PH_ACK_REL, PH_ACK_POLL, PH_ACK_LOW, PH_AFTER, PH_RX_LOW, PH_RX_HIGH,
    PH_RACK_SET, PH_RACK_HIGH, PH_RACK_LOW, PH_SP_HIGH, PH_SP_END
  } seq_phase_t;

  typedef enum logic [1:0] {
    STG_DEV_WR, STG_REG, STG_DEV_RD, STG_DATA
  } xfer_stage_t;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] dev;
    logic [7:0] reg_addr;
    logic [7:0] count;
    logic [7:0] wbyte;
    logic       sda;
  } bus_req_t;

  // same layout as out_tdata, lowest field last
  typedef struct packed {
    logic       pad;
    logic       busy;
    logic       done;
    logic       ack_err;
    logic       taken;
    logic       rvalid;
    logic [7:0] rdata;
    logic       sda;
    logic       scl;
  } tick_result_t;

  class tick_scoreboard;
    logic [15:0]  half_period, setup, hold;
    logic [7:0]   poll_limit;

    seq_phase_t   phase;
    xfer_stage_t  stage;
    logic [15:0]  wait_cnt;
    logic [3:0]   bit_idx;
    logic [7:0]   shreg, bytes_left, poll_cnt, reg_addr;
    logic [6:0]   dev;
    logic         rd, scl, sda, err;
    tick_result_t res;

    tick_result_t pending[$];
    int           served;
    int           errors;

    function new();
      half_period = HALF_PERIOD_RST;
      setup       = SETUP_RST;
      hold        = HOLD_RST;
      poll_limit  = POLL_LIMIT_RST;
      phase       = PH_IDLE;
      stage       = STG_DEV_WR;
      wait_cnt    = '0;
      bit_idx     = '0;
      shreg       = '0;
      bytes_left  = '0;
      poll_cnt    = '0;
      reg_addr    = '0;
      dev         = '0;
      rd          = 1'b0;
      scl         = 1'b1;
      sda         = 1'b1;
      err         = 1'b0;
      served      = 0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        REG_HALF_PERIOD: half_period = val;
        REG_SETUP:       setup       = val;
        REG_HOLD:        hold        = val;
        REG_POLL_LIMIT:  poll_limit  = val[7:0];
        default: ;
      endcase
    endfunction

    function void lines(logic c, logic d);
      scl = c;
      sda = d;
    endfunction

    function void go(seq_phase_t p, logic [15:0] w);
      phase    = p;
      wait_cnt = w;
    endfunction

    function void tx_bit();
      lines(1'b0, shreg[7]);
      shreg = shreg << 1;
      go(PH_TX_HIGH, setup);
    endfunction

    function void stop_begin();
      lines(1'b0, 1'b0);
      go(PH_SP_HIGH, half_period);
    endfunction

    // one bus action, taken when the current wait has run out
    function void act(logic s);
      case (phase)
        PH_ST_SDA: begin
          lines(1'b1, 1'b0);
          go(PH_ST_SCL, half_period);
        end
        PH_ST_SCL: begin
          scl     = 1'b0;
          shreg   = {dev, stage == STG_DEV_RD};
          bit_idx = '0;
          go(PH_TX_DATA, 16'd1);
        end
        PH_TX_DATA: tx_bit();
        PH_TX_HIGH: begin
          scl = 1'b1;
          go(PH_TX_LOW, half_period);
        end
        PH_TX_LOW: begin
          scl     = 1'b0;
          bit_idx = bit_idx + 4'd1;
          go(bit_idx < 4'd8 ? PH_TX_DATA : PH_ACK_REL, hold);
        end
        PH_ACK_REL: begin
          lines(1'b0, 1'b1);
          poll_cnt = '0;
          go(PH_ACK_POLL, half_period);
        end
        PH_ACK_POLL: begin
          if (s) begin
            if (poll_cnt >= poll_limit) begin
              err = 1'b1;
              stop_begin();
            end else begin
              poll_cnt = poll_cnt + 8'd1;
              go(PH_ACK_POLL, half_period);
            end
          end else begin
            scl = 1'b1;
            go(PH_ACK_LOW, half_period);
          end
        end
        PH_ACK_LOW, PH_RACK_LOW: begin
          scl = 1'b0;
          go(PH_AFTER, 16'd1);
        end
        PH_AFTER: begin
          if (stage == STG_DEV_WR) begin
            stage   = STG_REG;
            shreg   = reg_addr;
            bit_idx = '0;
            tx_bit();
          end else if (stage == STG_REG && rd) begin
            stage = STG_DEV_RD;
            lines(1'b1, 1'b1);
            go(PH_ST_SDA, half_period);
          end else if (!rd) begin
            stage = STG_DATA;
            if (bytes_left == 8'd0) begin
              stop_begin();
            end else begin
              bytes_left = bytes_left - 8'd1;
              res.taken  = 1'b1;
              bit_idx    = '0;
              tx_bit();
            end
          end else begin
            stage = STG_DATA;
            if (bytes_left == 8'd0) begin
              stop_begin();
            end else begin
              bit_idx = '0;
              lines(1'b0, 1'b1);
              go(PH_RX_HIGH, half_period);
            end
          end
        end
        PH_RX_LOW: begin
          lines(1'b0, 1'b1);
          go(PH_RX_HIGH, half_period);
        end
        PH_RX_HIGH: begin
          scl     = 1'b1;
          shreg   = {shreg[6:0], s};
          bit_idx = bit_idx + 4'd1;
          if (bit_idx >= 4'd8) begin
            res.rvalid = 1'b1;
            res.rdata  = shreg;
            bytes_left = bytes_left - 8'd1;
            go(PH_RACK_SET, half_period);
          end else begin
            go(PH_RX_LOW, half_period);
          end
        end
        PH_RACK_SET: begin
          // ACK every byte but the last, which gets NACK
          lines(1'b0, bytes_left == 8'd0);
          go(PH_RACK_HIGH, half_period);
        end
        PH_RACK_HIGH: begin
          scl = 1'b1;
          go(PH_RACK_LOW, half_period);
        end
        PH_SP_HIGH: begin
          lines(1'b1, 1'b1);
          go(PH_SP_END, half_period);
        end
        PH_SP_END: begin
          res.done    = 1'b1;
          res.ack_err = err;
          err         = 1'b0;
          go(PH_IDLE, 16'd0);
        end
        default: begin
          lines(1'b1, 1'b1);
          go(PH_IDLE, 16'd0);
        end
      endcase
    endfunction

    function tick_result_t predict_tick(bus_req_t r);
      res = '0;
      if (phase == PH_IDLE) begin
        if (r.op == OP_READ || r.op == OP_WRITE) begin
          dev        = r.dev;
          reg_addr   = r.reg_addr;
          bytes_left = r.count;
          rd         = (r.op == OP_READ);
          stage      = STG_DEV_WR;
          err        = 1'b0;
          lines(1'b1, 1'b1);
          go(PH_ST_SDA, half_period);
        end
      end else if (wait_cnt > 16'd1) begin
        wait_cnt = wait_cnt - 16'd1;
      end else begin
        // data byte is latched on each post-acknowledge tick of a write, taken or not
        if (phase == PH_AFTER && !rd && stage != STG_DEV_WR)
          shreg = r.wbyte;
        act(r.sda);
      end
      res.scl  = scl;
      res.sda  = sda;
      res.busy = (phase != PH_IDLE);
      return res;
    endfunction

    function void note_request(bus_req_t r);
      pending.push_back(predict_tick(r));
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(tick_result_t got);
      tick_result_t want;
      if (pending.size() == 0) begin
        $error("result %0h arrived with no request outstanding", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      served++;
      cmp_field("scl_level",   8'(want.scl),     8'(got.scl));
      cmp_field("sda_level",   8'(want.sda),     8'(got.sda));
      cmp_field("read_data",   want.rdata,       got.rdata);
      cmp_field("read_valid",  8'(want.rvalid),  8'(got.rvalid));
      cmp_field("write_taken", 8'(want.taken),   8'(got.taken));
      cmp_field("ack_error",   8'(want.ack_err), 8'(got.ack_err));
      cmp_field("done_res",    8'(want.done),    8'(got.done));
      cmp_field("busy_res",    8'(want.busy),    8'(got.busy));
      cmp_field("pad",         8'(want.pad),     8'(got.pad));
    endfunction
  endclass

endpackage

// ----- tb/i2c_master_register_access_unit_tb.sv -----
// ----------------------------------------------------------------------------
// i2c_master_register_access_unit_tb: I2C register master testbench
// Feeds bus ticks with a responsive target on SDA, predicts every line and
// status word per tick, and checks them in order across several timing
// settings and sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module i2c_master_register_access_unit_tb
  import i2cm_pkg::*, i2cm_tb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT  = 3000; // cycles with no handshake at all
  localparam int HOLD_OFF_CYCLES = 200;  // long receiver stall for back-pressure
  localparam int NACK_PCT        = 35;   // chance SDA reads high on an ack poll
  localparam int DRAIN_CYCLES    = 4;    // pipeline latency plus margin

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic [OP_W-1:0]   in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;

  tick_scoreboard sb;   // follows accepted requests
  tick_scoreboard gen;  // follows requests as they are generated

  int       items_sent     = 0;
  int       quiet_cycles   = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;
  bit       hold_off_req   = 1'b0;
  bit       dead_dev       = 1'b0; // target never acks in this transaction
  bus_req_t seen_req;

  i2c_master_register_access_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Request monitor, result checker and watchdog. Requests are noted before
  // results in the same edge; a result always trails its request anyway.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        seen_req.op       = in_tuser;
        seen_req.dev      = in_tdata[6:0];
        seen_req.reg_addr = in_tdata[14:7];
        seen_req.count    = in_tdata[22:15];
        seen_req.wbyte    = in_tdata[30:23];
        seen_req.sda      = in_tdata[31];
        sb.note_request(seen_req);
      end
      if (out_tvalid && out_tready)
        sb.check_result(tick_result_t'(out_tdata));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request so the
  // request queue fills and in_tready drops while the sender keeps offering.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Build one tick request, advance the generator-side model with it and
  // push it through the handshake. SDA plays the target: acks (or not) during
  // acknowledge waits, random data bits otherwise.
  task automatic send(input logic [OP_W-1:0] op, input logic [6:0] dev,
                      input logic [7:0] ra, input logic [7:0] cnt);
    bus_req_t r;
    r.op       = op;
    r.dev      = dev;
    r.reg_addr = ra;
    r.count    = cnt;
    r.wbyte    = 8'($urandom_range(0, 255));
    if (gen.phase inside {PH_ACK_REL, PH_ACK_POLL})
      r.sda = dead_dev || ($urandom_range(0, 99) < NACK_PCT);
    else
      r.sda = 1'($urandom_range(0, 1));
    void'(gen.predict_tick(r));
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r.sda, r.wbyte, r.count, r.reg_addr, r.dev};
    in_tuser  <= r.op;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Tick while a transaction runs; an occasional operation lands on a busy
  // sequencer and must be ignored. Fields roam their whole range.
  task automatic send_noise();
    send(($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : OP_TICK,
         7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
         8'($urandom_range(0, 255)));
  endtask

  task automatic run_transaction(input logic [OP_W-1:0] op, input logic [6:0] dev,
                                 input logic [7:0] ra, input logic [7:0] cnt,
                                 input bit dead);
    dead_dev = dead;
    send(op, dev, ra, cnt);
    // a second begin right behind the first is ignored
    if (gen.phase != PH_IDLE)
      send(OP_WRITE, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 8'd1);
    while (gen.phase != PH_IDLE)
      send_noise();
    dead_dev = 1'b0;
  endtask

  // Wait until every request sent so far has its result checked.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.served != items_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    gen.write_reg(idx, val);
    @(posedge clk);
  endtask

  // Drain the block, then load all four timing registers.
  task automatic set_timing(input logic [15:0] h, input logic [15:0] s,
                            input logic [15:0] hd, input logic [7:0] pl);
    settle();
    cfg_write(REG_HALF_PERIOD, h);
    cfg_write(REG_SETUP, s);
    cfg_write(REG_HOLD, hd);
    cfg_write(REG_POLL_LIMIT, {8'd0, pl});
    cfg_we <= 1'b0;
  endtask

  // One timing setting and idle pattern, then random transactions. The last
  // transaction is run to its end so the next setting starts from idle.
  task automatic run_phase(input logic [15:0] h, input logic [15:0] s,
                           input logic [15:0] hd, input logic [7:0] pl,
                           input int snd, input int rcv, input int n,
                           input bit starts, input bit pressure);
    int unsigned     pick;
    logic [OP_W-1:0] op;
    logic [7:0]      cnt;
    set_timing(h, s, hd, pl);
    send_idle_pct  = snd;
    recv_stall_pct = rcv;
    if (pressure)
      hold_off_req = 1'b1;
    repeat (n) begin
      if (gen.phase == PH_IDLE) begin
        pick     = $urandom_range(0, 9);
        dead_dev = ($urandom_range(0, 7) == 0);
        if (starts && pick < 4)
          op = OP_READ;
        else if (starts && pick < 8)
          op = OP_WRITE;
        else if (pick[0])
          op = OP_RESERVED;
        else
          op = OP_TICK;
        // mostly short transfers, a few longer ones
        cnt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 12))
                                          : 8'($urandom_range(0, 2));
        send(op, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), cnt);
      end else begin
        send_noise();
      end
    end
    while (gen.phase != PH_IDLE)
      send_noise();
    dead_dev = 1'b0;
  endtask

  initial begin
    sb  = new();
    gen = new();
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_HALF_PERIOD;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_TICK;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset timing (5/2/3/50), no idling.
    // silent target: address byte, every poll up to the reset limit, stop,
    // error on the done tick
    run_transaction(OP_WRITE, 7'h7F, 8'hFF, 8'hFF, 1'b1);
    // operation three and a plain tick leave the sequencer idle
    run_transaction(OP_RESERVED, 7'h7F, 8'hFF, 8'hFF, 1'b0);
    run_transaction(OP_TICK, 7'h7F, 8'hFF, 8'hFF, 1'b0);

    // Directed, fastest timing with a short poll limit.
    set_timing(16'd1, 16'd0, 16'd0, 8'd2);
    // write with no data bytes: both address bytes, then stop
    run_transaction(OP_WRITE, 7'h7F, 8'hFF, 8'd0, 1'b0);
    // read with no data bytes: repeated start and read address, then stop
    run_transaction(OP_READ, 7'h00, 8'h00, 8'd0, 1'b0);
    run_transaction(OP_WRITE, 7'h2A, 8'h5A, 8'd1, 1'b0);
    // ACK on the first byte, NACK on the last
    run_transaction(OP_READ, 7'h55, 8'hA5, 8'd2, 1'b0);
    // silent target on a read
    run_transaction(OP_READ, 7'h01, 8'h80, 8'd1, 1'b1);

    // Random: fastest timing with the longest poll limit, then mixed
    // settings under each idle pattern, one with a long receiver hold-off.
    run_phase(16'd1, 16'd0, 16'd0, 8'd255,  0,  0, 60, 1'b1, 1'b0);
    run_phase(16'd1, 16'd0, 16'd0, 8'd1,   66,  0, 60, 1'b1, 1'b0);
    run_phase(16'd2, 16'd1, 16'd1, 8'd3,    0, 66, 60, 1'b1, 1'b0);
    run_phase(16'd1, 16'd2, 16'd0, 8'd2,   26, 26, 60, 1'b1, 1'b0);
    run_phase(16'd3, 16'd0, 16'd2, 8'd1,    0,  0, 60, 1'b1, 1'b1);
    // largest timing values: far too slow for a transfer, idle ticks only
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 26, 26, 30, 1'b0, 1'b0);
    run_phase(16'd1, 16'd0, 16'd0, 8'd1,   26, 26, 60, 1'b1, 1'b0);

    settle();
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
